// ----- rtl/core/byte_ring_fifo_with_search_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH

// a holds -> c holds in the same cycle
`define BRFS_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("brfs assertion failed");

// a holds -> c holds in the next cycle
`define BRFS_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("brfs assertion failed");

`endif

// ----- rtl/core/brfs_pkg.sv -----
`timescale 1ns / 1ps

package brfs_pkg;

   localparam int IDX_W  = 8;
   localparam int SIZE_W = 9;
   localparam int CNT_W  = 4;
   localparam int LANE_W = 3;
   localparam int DATA_W = 64;
   localparam int CMD_W  = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;

   localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_COMPARE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] byte_lane_data;
      logic [CNT_W-1:0]  byte_count;
      logic [IDX_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] read_bytes;
      logic [IDX_W-1:0]  found_index;
      logic [IDX_W-1:0]  fill_count;
      logic [IDX_W-1:0]  free_space;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic eval;
      logic mod_step;
      logic rd_issue;
      logic rd_check;
      logic wr_step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_put;
      logic op_get;
      logic op_find;
      logic op_cmp;
      logic put_ok;
      logic get_ok;
      logic cnt_zero;
      logic cnt_over;
      logic ring_empty;
      logic step_done;
      logic mod_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/core/brfs_ctrl.sv -----
`timescale 1ns / 1ps

module brfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  brfs_pkg::dp_status_type stat,
   output brfs_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_EVAL     = 7'b0000010,
      ST_MOD      = 7'b0000100,
      ST_RD_ADDR  = 7'b0001000,
      ST_RD_CHECK = 7'b0010000,
      ST_WRITE    = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.op_put) begin
               state_in = (stat.put_ok && !stat.cnt_zero) ? ST_WRITE : ST_FINISH;
            end else if (stat.op_get) begin
               state_in = (stat.get_ok && !stat.cnt_zero) ? ST_RD_ADDR : ST_FINISH;
            end else if (stat.op_find) begin
               state_in = (!stat.cnt_zero && !stat.ring_empty) ? ST_RD_ADDR : ST_FINISH;
            end else if (stat.op_cmp) begin
               state_in = stat.cnt_over ? ST_FINISH : ST_MOD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MOD: begin
            if (stat.mod_last) state_in = stat.cnt_zero ? ST_FINISH : ST_RD_ADDR;
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_CHECK;
         end
         ST_RD_CHECK: begin
            state_in = stat.step_done ? ST_FINISH : ST_RD_ADDR;
         end
         ST_WRITE: begin
            if (stat.step_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.latch    = (state_ff == ST_IDLE) && req_valid;
   assign cmd.eval     = (state_ff == ST_EVAL);
   assign cmd.mod_step = (state_ff == ST_MOD);
   assign cmd.rd_issue = (state_ff == ST_RD_ADDR);
   assign cmd.rd_check = (state_ff == ST_RD_CHECK);
   assign cmd.wr_step  = (state_ff == ST_WRITE);
   assign cmd.finish   = (state_ff == ST_FINISH) && stat.rsp_free;

endmodule

// ----- rtl/core/brfs_datapath.sv -----
`timescale 1ns / 1ps

module brfs_datapath #(
   parameter int DEPTH     = 256,
   parameter int MAX_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  brfs_pkg::req_type                   req_item,
   input  logic                                csr_write_en,
   input  logic [brfs_pkg::SIZE_W-1:0]         csr_write_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output brfs_pkg::rsp_type                   rsp_item,
   input  brfs_pkg::ctrl_cmd_type              cmd,
   output brfs_pkg::dp_status_type             stat
);

   localparam int LIM = (DEPTH < 256) ? DEPTH : 256;
   localparam int AW  = $clog2(LIM);
   localparam logic [brfs_pkg::SIZE_W-1:0] LIM_SIZE = brfs_pkg::SIZE_W'(LIM);
   localparam logic [brfs_pkg::CNT_W-1:0]  MAX_CNT  = brfs_pkg::CNT_W'(MAX_BYTES);

   localparam int IW = brfs_pkg::IDX_W;
   localparam int SW = brfs_pkg::SIZE_W;
   localparam int CW = brfs_pkg::CNT_W;
   localparam int LW = brfs_pkg::LANE_W;

   logic [7:0] mem [LIM];

   logic [SW-1:0]               ring_size_ff;
   logic [IW-1:0]               read_idx_ff;
   logic [IW-1:0]               write_idx_ff;
   logic                        rsp_valid_ff;
   brfs_pkg::req_type           item_ff;
   brfs_pkg::rsp_type           rsp_ff;
   logic [IW-1:0]               ptr_ff;
   logic [LW-1:0]               k_ff;
   logic [LW-1:0]               n_ff;
   logic [IW-1:0]               rem_ff;
   logic [LW-1:0]               mstep_ff;
   logic                        ok_ff;
   logic [IW-1:0]               found_ff;
   logic [brfs_pkg::DATA_W-1:0] rd_ff;
   logic [7:0]                  rdata_ff;

   logic [SW-1:0] size;
   logic [SW-1:0] fill9;
   logic [SW-1:0] free9;
   logic [CW-1:0] cnt;
   logic [CW-1:0] flen;
   logic          op_put, op_get, op_find, op_cmp, op_clr;
   logic          cnt_zero, cnt_over, put_ok, get_ok;
   logic [SW-1:0] ptr_inc;
   logic [IW-1:0] ptr_next;
   logic          k_last;
   logic [7:0]    lane_k, lane_n;
   logic          cmp_hit, find_hit, find_full, find_at_w;
   logic [LW-1:0] n_new;
   logic [IW-1:0] found_match, found_miss;
   logic          step_done;
   logic [15:0]   mod_sub;
   logic [IW-1:0] rem_next;

   function automatic logic [IW-1:0] sub_wrap(input logic [IW-1:0] p,
                                               input logic [LW-1:0] m,
                                               input logic [SW-1:0] s);
      logic [SW-1:0] wide;
      if ({1'b0, p} >= {{(SW-LW){1'b0}}, m}) begin
         wide = {1'b0, p} - {{(SW-LW){1'b0}}, m};
      end else begin
         wide = {1'b0, p} + s - {{(SW-LW){1'b0}}, m};
      end
      return wide[IW-1:0];
   endfunction

   always_comb begin
      if (ring_size_ff < brfs_pkg::SIZE_MIN) begin
         size = brfs_pkg::SIZE_MIN;
      end else if (ring_size_ff > LIM_SIZE) begin
         size = LIM_SIZE;
      end else begin
         size = ring_size_ff;
      end
   end

   always_comb begin
      if (write_idx_ff >= read_idx_ff) begin
         fill9 = {1'b0, write_idx_ff} - {1'b0, read_idx_ff};
      end else begin
         fill9 = {1'b0, write_idx_ff} + size - {1'b0, read_idx_ff};
      end
   end
   assign free9 = size - 9'd1 - fill9;

   assign cnt      = item_ff.byte_count;
   assign op_put   = (item_ff.cmd == brfs_pkg::CMD_PUT);
   assign op_get   = (item_ff.cmd == brfs_pkg::CMD_GET);
   assign op_find  = (item_ff.cmd == brfs_pkg::CMD_FIND);
   assign op_cmp   = (item_ff.cmd == brfs_pkg::CMD_COMPARE);
   assign op_clr   = (item_ff.cmd == brfs_pkg::CMD_CLEAR);
   assign cnt_zero = (cnt == '0);
   assign cnt_over = (cnt > MAX_CNT);
   assign flen     = cnt_over ? MAX_CNT : cnt;
   assign put_ok   = !cnt_over && ({{(SW-CW){1'b0}}, cnt} <= free9);
   assign get_ok   = (fill9 != '0) && !cnt_over && ({{(SW-CW){1'b0}}, cnt} <= fill9);

   assign ptr_inc  = {1'b0, ptr_ff} + 9'd1;
   assign ptr_next = (ptr_inc == size) ? '0 : ptr_inc[IW-1:0];
   assign k_last   = (({1'b0, k_ff} + 4'd1) == cnt);

   assign lane_k    = item_ff.byte_lane_data[{k_ff, 3'b000} +: 8];
   assign lane_n    = item_ff.byte_lane_data[{n_ff, 3'b000} +: 8];
   assign cmp_hit   = (rdata_ff == lane_k);
   assign find_hit  = (rdata_ff == lane_n);
   assign find_full = find_hit && (({1'b0, n_ff} + 4'd1) == flen);
   assign find_at_w = (ptr_next == write_idx_ff);
   assign n_new     = find_hit ? n_ff + 3'd1 : '0;

   assign found_match = sub_wrap(ptr_ff, n_ff, size);
   assign found_miss  = sub_wrap(write_idx_ff, n_new, size);

   always_comb begin
      case (item_ff.cmd)
         brfs_pkg::CMD_PUT:     step_done = k_last;
         brfs_pkg::CMD_GET:     step_done = k_last;
         brfs_pkg::CMD_FIND:    step_done = find_full || find_at_w;
         brfs_pkg::CMD_COMPARE: step_done = !cmp_hit || k_last;
         default:               step_done = 1'b1;
      endcase
   end

   // restoring remainder of position by the ring size, one quotient bit a cycle
   assign mod_sub  = 16'(size) << mstep_ff;
   assign rem_next = ({8'b0, rem_ff} >= mod_sub) ? rem_ff - mod_sub[IW-1:0] : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_step) mem[ptr_ff[AW-1:0]] <= lane_k;
      if (cmd.rd_issue) rdata_ff <= mem[ptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= brfs_pkg::SIZE_RESET;
         read_idx_ff  <= '0;
         write_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            ring_size_ff <= csr_write_data;
            read_idx_ff  <= '0;
            write_idx_ff <= '0;
         end
         if (cmd.eval && op_clr) begin
            read_idx_ff  <= '0;
            write_idx_ff <= '0;
         end
         if (cmd.wr_step && k_last) write_idx_ff <= ptr_next;
         if (cmd.rd_check && op_get && k_last) read_idx_ff <= ptr_next;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) item_ff <= req_item;
      if (cmd.eval) begin
         if (op_put) begin
            ptr_ff <= write_idx_ff;
         end else if (op_get || op_find) begin
            ptr_ff <= read_idx_ff;
         end
         k_ff     <= '0;
         n_ff     <= '0;
         rd_ff    <= '0;
         rem_ff   <= item_ff.position;
         mstep_ff <= '1;
         found_ff <= (op_find && !cnt_zero) ? write_idx_ff : '0;
         case (item_ff.cmd)
            brfs_pkg::CMD_PUT:     ok_ff <= put_ok;
            brfs_pkg::CMD_GET:     ok_ff <= get_ok;
            brfs_pkg::CMD_COMPARE: ok_ff <= !cnt_over;
            brfs_pkg::CMD_CLEAR:   ok_ff <= 1'b1;
            default:               ok_ff <= 1'b0;
         endcase
      end
      if (cmd.mod_step) begin
         rem_ff   <= rem_next;
         mstep_ff <= mstep_ff - 3'd1;
         if (mstep_ff == '0) ptr_ff <= rem_next;
      end
      if (cmd.wr_step) begin
         k_ff   <= k_ff + 3'd1;
         ptr_ff <= ptr_next;
      end
      if (cmd.rd_check) begin
         ptr_ff <= ptr_next;
         if (op_get) begin
            rd_ff[{k_ff, 3'b000} +: 8] <= rdata_ff;
            k_ff <= k_ff + 3'd1;
         end else if (op_cmp) begin
            if (!cmp_hit) ok_ff <= 1'b0;
            k_ff <= k_ff + 3'd1;
         end else if (op_find) begin
            n_ff <= n_new;
            if (find_full) begin
               found_ff <= found_match;
            end else if (find_at_w) begin
               found_ff <= found_miss;
            end
         end
      end
      if (cmd.finish) begin
         rsp_ff.ok          <= ok_ff;
         rsp_ff.read_bytes  <= rd_ff;
         rsp_ff.found_index <= found_ff;
         rsp_ff.fill_count  <= fill9[IW-1:0];
         rsp_ff.free_space  <= free9[IW-1:0];
      end
   end

   assign stat.op_put     = op_put;
   assign stat.op_get     = op_get;
   assign stat.op_find    = op_find;
   assign stat.op_cmp     = op_cmp;
   assign stat.put_ok     = put_ok;
   assign stat.get_ok     = get_ok;
   assign stat.cnt_zero   = cnt_zero;
   assign stat.cnt_over   = cnt_over;
   assign stat.ring_empty = (read_idx_ff == write_idx_ff);
   assign stat.step_done  = step_done;
   assign stat.mod_last   = (mstep_ff == '0);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- rtl/core/byte_ring_fifo_with_search.sv -----
// Clear, unknown and rejected commands go straight to the result; put writes its n bytes,
// get reads its n bytes, find scans m bytes, and compare checks n bytes, stopping at the first
// mismatch. Each byte read issues its address to the registered memory read port and then checks
// the registered byte; compare first reduces position by the ring size. One command at a
// time; the next is taken the cycle after its result is registered. Sync reset: indices zero,
// size 256, storage not cleared.
`timescale 1ns / 1ps

module byte_ring_fifo_with_search #(
   parameter int DEPTH     = 256,
   parameter int MAX_BYTES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  brfs_pkg::req_type           req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output brfs_pkg::rsp_type           rsp_item,
   input  logic                        csr_write_en,
   input  logic [brfs_pkg::SIZE_W-1:0] csr_write_data
);

   brfs_pkg::ctrl_cmd_type  cmd;
   brfs_pkg::dp_status_type stat;

   brfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brfs_datapath #(
      .DEPTH     (DEPTH),
      .MAX_BYTES (MAX_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_item       (req_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

// ----- rtl/core/brfs_checker.sv -----
`timescale 1ns / 1ps
`include "byte_ring_fifo_with_search_defines.svh"

module brfs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input brfs_pkg::rsp_type rsp_item
);

   `BRFS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))
   `BRFS_ASSERT_IMP(a_found_not_ok, clock, reset, rsp_valid && (rsp_item.found_index != 8'd0), !rsp_item.ok)
   `BRFS_ASSERT_IMP(a_bytes_need_ok, clock, reset, rsp_valid && (rsp_item.read_bytes != 64'd0), rsp_item.ok)
   `BRFS_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `BRFS_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind byte_ring_fifo_with_search brfs_checker u_checker (.*);
